// ----- rtl/stt_pkg.sv -----
// Shared types and constants for the script text tokenizer.
// Holds the scan mode enum, result word layout and queue sizing.
// No dependencies.
package stt_pkg;

    typedef enum logic [2:0] {
        MODE_SKIP    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_PLAIN   = 3'd2,
        MODE_QUOTED  = 3'd3,
        MODE_DROP    = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        KIND_CHAR       = 2'd0,
        KIND_TOKEN_END  = 2'd1,
        KIND_SCRIPT_END = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        REG_COMMENT_CHAR = 2'd0,
        REG_QUOTE_CHAR   = 2'd1,
        REG_MAX_CHARS    = 2'd2
    } t_reg_idx;

    localparam int unsigned RUN_ITEMS = 3;
    localparam int unsigned Q_DEPTH   = 4;
    localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);

    localparam logic [7:0] WS_MAX     = 8'd32;
    localparam logic [7:0] NEWLINE    = 8'd10;
    localparam logic [7:0] RST_COMMENT = 8'd59;
    localparam logic [7:0] RST_QUOTE   = 8'd34;
    localparam logic [7:0] RST_MAX     = 8'd63;

    // one result word without its line number
    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic       quoted;
        logic [7:0] len;
    } t_item;

    // all result words caused by one input byte
    typedef struct packed {
        logic [1:0]                 count;
        t_item [RUN_ITEMS-1:0]      items;
    } t_run;

    localparam int unsigned RUN_W = $bits(t_run);

endpackage

// ----- rtl/stt_front.sv -----
// Front end: holds config registers and scan state, classifies each byte
// and builds the run of result words it causes.
// Depends on stt_pkg.
module stt_front #(
    parameter int unsigned LINE_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_accept,
    input  logic [7:0]           i_text_byte,
    input  logic                 i_final_byte,
    output logic                 o_run_valid,
    output stt_pkg::t_run        o_run,
    output logic [LINE_BITS-1:0] o_line_tok,
    output logic [LINE_BITS-1:0] o_line_end
);
    import stt_pkg::*;

    localparam logic [LINE_BITS-1:0] LINE_ONE = {{(LINE_BITS-1){1'b0}}, 1'b1};
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    logic [7:0]           r_comment_char;
    logic [7:0]           r_quote_char;
    logic [7:0]           r_max_chars;
    t_mode                r_mode, n_mode;
    logic [7:0]           r_cnt, n_cnt;
    logic [LINE_BITS-1:0] r_line, n_line;

    logic [7:0]           eff_max;
    logic                 is_ws, is_cc, is_qc, is_nl;
    logic                 take, take_q, pre_end, pre_q, bump, cut;
    logic [7:0]           take_base, cnt1, cnt_step;
    t_mode                mode_step;
    logic [LINE_BITS-1:0] line_step;

    assign eff_max = (r_max_chars == 8'd0) ? 8'd1 : r_max_chars;
    assign is_ws   = (i_text_byte <= WS_MAX);
    assign is_cc   = (i_text_byte == r_comment_char);
    assign is_qc   = (i_text_byte == r_quote_char);
    assign is_nl   = (i_text_byte == NEWLINE);

    // classify the byte against the current mode
    always_comb begin
        take      = 1'b0;
        take_q    = 1'b0;
        pre_end   = 1'b0;
        pre_q     = 1'b0;
        bump      = 1'b0;
        take_base = r_cnt;
        cnt_step  = r_cnt;
        mode_step = r_mode;
        unique case (r_mode)
            MODE_SKIP: begin
                if (is_ws) begin
                    mode_step = MODE_SKIP;
                    bump      = is_nl;
                end else if (is_cc) begin
                    mode_step = MODE_COMMENT;
                end else if (is_qc) begin
                    mode_step = MODE_QUOTED;
                    cnt_step  = 8'd0;
                end else begin
                    take      = 1'b1;
                    take_base = 8'd0;
                end
            end
            MODE_COMMENT: begin
                if (is_nl) begin
                    mode_step = MODE_SKIP;
                    bump      = 1'b1;
                end
            end
            MODE_PLAIN: begin
                if (!is_ws && !is_cc) begin
                    take = 1'b1;
                end else begin
                    pre_end = 1'b1;
                    if (is_ws) begin
                        mode_step = MODE_SKIP;
                        bump      = is_nl;
                    end else begin
                        mode_step = MODE_COMMENT;
                    end
                end
            end
            MODE_QUOTED: begin
                if (is_qc) begin
                    pre_end   = 1'b1;
                    pre_q     = 1'b1;
                    mode_step = MODE_SKIP;
                end else begin
                    take   = 1'b1;
                    take_q = 1'b1;
                end
            end
            MODE_DROP: begin
                mode_step = MODE_SKIP;
            end
            default: begin
                mode_step = MODE_SKIP;
            end
        endcase
        cnt1 = take_base + 8'd1;
        cut  = take && (cnt1 >= eff_max);
        if (take) begin
            cnt_step = cnt1;
            if (cut) begin
                mode_step = take_q ? MODE_DROP : MODE_SKIP;
            end else begin
                mode_step = take_q ? MODE_QUOTED : MODE_PLAIN;
            end
        end
        line_step = (bump && (r_line != LINE_MAX)) ? r_line + LINE_ONE : r_line;
    end

    // next state
    always_comb begin
        if (i_final_byte) begin
            n_mode = MODE_SKIP;
            n_cnt  = 8'd0;
            n_line = LINE_ONE;
        end else begin
            n_mode = mode_step;
            n_cnt  = cnt_step;
            n_line = line_step;
        end
    end

    // result words
    always_comb begin
        t_item      cand [RUN_ITEMS];
        logic       en   [RUN_ITEMS];
        logic [1:0] n;
        logic       fin_open;
        fin_open = i_final_byte &&
                   ((mode_step == MODE_PLAIN) || (mode_step == MODE_QUOTED));

        cand[0].kind   = pre_end ? KIND_TOKEN_END : KIND_CHAR;
        cand[0].ch     = pre_end ? 8'd0 : i_text_byte;
        cand[0].quoted = pre_end ? pre_q : take_q;
        cand[0].len    = pre_end ? r_cnt : cnt1;
        en[0]          = pre_end || take;

        cand[1].kind   = KIND_TOKEN_END;
        cand[1].ch     = 8'd0;
        cand[1].quoted = cut ? take_q : (mode_step == MODE_QUOTED);
        cand[1].len    = cnt_step;
        en[1]          = cut || fin_open;

        cand[2].kind   = KIND_SCRIPT_END;
        cand[2].ch     = 8'd0;
        cand[2].quoted = 1'b0;
        cand[2].len    = 8'd0;
        en[2]          = i_final_byte;

        o_run = '0;
        n     = 2'd0;
        for (int k = 0; k < RUN_ITEMS; k++) begin
            if (en[k]) begin
                o_run.items[n] = cand[k];
                n = n + 2'd1;
            end
        end
        o_run.count = n;
        o_run_valid = (n != 2'd0);
    end

    assign o_line_tok = r_line;
    assign o_line_end = line_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_SKIP;
            r_cnt          <= 8'd0;
            r_line         <= LINE_ONE;
            r_comment_char <= RST_COMMENT;
            r_quote_char   <= RST_QUOTE;
            r_max_chars    <= RST_MAX;
        end else begin
            if (i_accept) begin
                r_mode <= n_mode;
                r_cnt  <= n_cnt;
                r_line <= n_line;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_COMMENT_CHAR: r_comment_char <= i_cfg_data;
                    REG_QUOTE_CHAR:   r_quote_char   <= i_cfg_data;
                    REG_MAX_CHARS:    r_max_chars    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- rtl/stt_queue.sv -----
// Short register queue of result runs between front and back.
// Depends on stt_pkg for depth constants.
module stt_queue #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_rdata
);
    import stt_pkg::*;

    localparam logic [Q_PTR_W:0] DEPTH_CNT = (Q_PTR_W + 1)'(Q_DEPTH);

    logic [WIDTH-1:0]   r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_PTR_W:0]   r_fill;
    logic               do_push, do_pop;

    assign o_full  = (r_fill == DEPTH_CNT);
    assign o_empty = (r_fill == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/stt_back.sv -----
// Back end: takes one run at a time from the queue and hands its result
// words out one per pop. Depends on stt_pkg.
module stt_back #(
    parameter int unsigned LINE_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  stt_pkg::t_run        i_run,
    input  logic [LINE_BITS-1:0] i_line_tok,
    input  logic [LINE_BITS-1:0] i_line_end,
    output logic                 o_q_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic [1:0]           o_kind,
    output logic [7:0]           o_char_value,
    output logic                 o_is_quoted,
    output logic [7:0]           o_token_length,
    output logic [LINE_BITS-1:0] o_line_number,
    output logic                 o_last_of_run
);
    import stt_pkg::*;

    logic                 r_valid;
    logic [1:0]           r_idx;
    t_run                 r_run;
    logic [LINE_BITS-1:0] r_line_tok, r_line_end;
    logic                 last, take_out, load;
    t_item                cur;

    assign cur      = r_run.items[r_idx];
    assign last     = (r_idx == (r_run.count - 2'd1));
    assign take_out = r_valid && i_pop;
    assign load     = !i_q_empty && (!r_valid || (take_out && last));
    assign o_q_pop  = load;

    assign o_empty        = !r_valid;
    assign o_kind         = cur.kind;
    assign o_char_value   = cur.ch;
    assign o_is_quoted    = cur.quoted;
    assign o_token_length = cur.len;
    assign o_line_number  = (cur.kind == KIND_SCRIPT_END) ? r_line_end : r_line_tok;
    assign o_last_of_run  = last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_run      <= i_run;
            r_line_tok <= i_line_tok;
            r_line_end <= i_line_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= 2'd0;
            end else if (take_out) begin
                if (last) begin
                    r_valid <= 1'b0;
                    r_idx   <= 2'd0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
        end
    end

endmodule

// ----- rtl/script_text_tokenizer.sv -----
// Top level of the script text tokenizer.
// Depends on stt_pkg, stt_front, stt_queue and stt_back.
//
// Usage:
//   Input channel: drive i_text_byte/i_final_byte with i_push; a word is
//   taken on a clock edge with i_push high and o_full low.
//   Result channel: while o_empty is low the oldest result word is on the
//   o_ ports; i_pop high on a clock edge takes it.
//   Config: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 comment char, 1 quote char, 2 max token chars); write only when idle.
// Timing:
//   One input byte is taken per cycle while the run queue has room. A byte
//   makes zero to three result words; the first reaches the outputs via the
//   run queue and the back end's run register, and words leave at one per
//   cycle, so the output side (one word per pop) sets the sustained rate.
//   A stalled receiver fills the four-run queue, then o_full holds input.
// Reset: i_rst_n low on a clock edge clears scan state, line count (to 1),
//   queue and output, and restores register defaults.
module script_text_tokenizer #(
    parameter int unsigned LINE_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [7:0]           i_text_byte,
    input  logic                 i_final_byte,
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic [1:0]           o_kind,
    output logic [7:0]           o_char_value,
    output logic                 o_is_quoted,
    output logic [7:0]           o_token_length,
    output logic [LINE_BITS-1:0] o_line_number,
    output logic                 o_last_of_run
);
    import stt_pkg::*;

    localparam int unsigned QW = RUN_W + 2 * LINE_BITS;

    logic                 accept;
    logic                 run_valid;
    t_run                 f_run, b_run;
    logic [LINE_BITS-1:0] f_line_tok, f_line_end, b_line_tok, b_line_end;
    logic [QW-1:0]        q_wdata, q_rdata;
    logic                 q_empty, q_pop;

    assign accept  = i_push && !o_full;
    assign q_wdata = {f_run, f_line_tok, f_line_end};
    assign {b_run, b_line_tok, b_line_end} = q_rdata;

    stt_front #(
        .LINE_BITS (LINE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_text_byte  (i_text_byte),
        .i_final_byte (i_final_byte),
        .o_run_valid  (run_valid),
        .o_run        (f_run),
        .o_line_tok   (f_line_tok),
        .o_line_end   (f_line_end)
    );

    stt_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && run_valid),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_full  (o_full),
        .o_empty (q_empty),
        .o_rdata (q_rdata)
    );

    stt_back #(
        .LINE_BITS (LINE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_run          (b_run),
        .i_line_tok     (b_line_tok),
        .i_line_end     (b_line_end),
        .o_q_pop        (q_pop),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_kind         (o_kind),
        .o_char_value   (o_char_value),
        .o_is_quoted    (o_is_quoted),
        .o_token_length (o_token_length),
        .o_line_number  (o_line_number),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for script_text_tokenizer: directed rows, then scripted random phases.
// Predicts every result word from its own scan-state copy and checks words field by field.
// Depends on stt_pkg and the script_text_tokenizer RTL.
module tb_top;
    import stt_pkg::*;

    localparam int LINE_W      = 8;    // narrowest line counter
    localparam int SETTLE      = 24;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        t_kind             kind;
        logic [7:0]        ch;
        logic              quoted;
        logic [7:0]        len;
        logic [LINE_W-1:0] line;
        logic              last;
    } tok_word_t;

    typedef struct {
        logic [7:0]        b;
        logic              fin;
        bit                pinned;
        t_kind             kind;
        logic [7:0]        ch;
        logic              quoted;
        logic [7:0]        len;
        logic [LINE_W-1:0] line;
    } stim_row_t;

    typedef struct {
        logic [7:0] cmt;
        logic [7:0] quo;
        logic [7:0] cap;
        bit         rand_cfg;
        bit         hold;
        bit         idle;
        int         items;
    } phase_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    t_reg_idx          i_cfg_index;
    logic [7:0]        i_cfg_data;
    logic              i_push;
    logic              o_full;
    logic [7:0]        i_text_byte;
    logic              i_final_byte;
    logic              o_empty;
    logic              i_pop;
    logic [1:0]        o_kind;
    logic [7:0]        o_char_value;
    logic              o_is_quoted;
    logic [7:0]        o_token_length;
    logic [LINE_W-1:0] o_line_number;
    logic              o_last_of_run;

    // predictor state and register copies
    t_mode             scan_mode_m;
    logic [7:0]        chars_m;
    logic [LINE_W-1:0] line_m;
    logic [7:0]        comment_m;
    logic [7:0]        quote_m;
    logic [7:0]        max_m;

    tok_word_t expected_words[$];
    stim_row_t script_bytes[$];
    stim_row_t cur_row;
    int        err_count = 0;
    bit        idle_on;
    bit        hold_req;

    // byte, final, pinned, then the pinned first word: kind, char, quoted, length, line
    stim_row_t directed_rows [25] = '{
        '{8'h41, 1'b0, 1'b1, KIND_CHAR,       8'h41, 1'b0, 8'd1, 1},
        '{8'hFF, 1'b0, 1'b1, KIND_CHAR,       8'hFF, 1'b0, 8'd2, 1},
        '{8'h00, 1'b0, 1'b1, KIND_TOKEN_END,  8'h00, 1'b0, 8'd2, 1},
        '{8'h20, 1'b0, 1'b0, KIND_CHAR,       8'h00, 1'b0, 8'd0, 0},
        '{8'h21, 1'b0, 1'b1, KIND_CHAR,       8'h21, 1'b0, 8'd1, 1},
        '{8'h0A, 1'b0, 1'b1, KIND_TOKEN_END,  8'h00, 1'b0, 8'd1, 1},
        '{8'h3B, 1'b0, 1'b0, KIND_CHAR,       8'h00, 1'b0, 8'd0, 0},
        '{8'h78, 1'b0, 1'b0, KIND_CHAR,       8'h00, 1'b0, 8'd0, 0},
        '{8'h0A, 1'b0, 1'b0, KIND_CHAR,       8'h00, 1'b0, 8'd0, 0},
        '{8'h22, 1'b0, 1'b0, KIND_CHAR,       8'h00, 1'b0, 8'd0, 0},
        '{8'h0A, 1'b0, 1'b1, KIND_CHAR,       8'h0A, 1'b1, 8'd1, 3},
        '{8'h3B, 1'b0, 1'b0, KIND_CHAR,       8'h00, 1'b0, 8'd0, 0},
        '{8'h20, 1'b0, 1'b0, KIND_CHAR,       8'h00, 1'b0, 8'd0, 0},
        '{8'h22, 1'b0, 1'b1, KIND_TOKEN_END,  8'h00, 1'b1, 8'd3, 3},
        '{8'h61, 1'b0, 1'b0, KIND_CHAR,       8'h00, 1'b0, 8'd0, 0},
        '{8'h3B, 1'b0, 1'b1, KIND_TOKEN_END,  8'h00, 1'b0, 8'd1, 3},
        '{8'h0A, 1'b0, 1'b0, KIND_CHAR,       8'h00, 1'b0, 8'd0, 0},
        '{8'h22, 1'b0, 1'b0, KIND_CHAR,       8'h00, 1'b0, 8'd0, 0},
        '{8'h71, 1'b1, 1'b1, KIND_CHAR,       8'h71, 1'b1, 8'd1, 4},
        '{8'h7A, 1'b1, 1'b1, KIND_CHAR,       8'h7A, 1'b0, 8'd1, 1},
        '{8'h20, 1'b1, 1'b1, KIND_SCRIPT_END, 8'h00, 1'b0, 8'd0, 1},
        '{8'h3B, 1'b0, 1'b0, KIND_CHAR,       8'h00, 1'b0, 8'd0, 0},
        '{8'h63, 1'b1, 1'b1, KIND_SCRIPT_END, 8'h00, 1'b0, 8'd0, 1},
        '{8'h0A, 1'b0, 1'b0, KIND_CHAR,       8'h00, 1'b0, 8'd0, 0},
        '{8'hFF, 1'b1, 1'b1, KIND_CHAR,       8'hFF, 1'b0, 8'd1, 2}
    };

    // comment, quote, max, random regs, long receiver hold, idling, bytes
    phase_t phases [8] = '{
        '{8'd59,  8'd34,  8'd2,   1'b0, 1'b1, 1'b1, 30},
        '{8'd35,  8'd39,  8'd1,   1'b0, 1'b0, 1'b1, 28},
        '{8'd255, 8'd0,   8'd255, 1'b0, 1'b0, 1'b1, 30},
        '{8'd33,  8'd33,  8'd0,   1'b0, 1'b0, 1'b1, 25},
        '{8'd32,  8'd126, 8'd3,   1'b0, 1'b0, 1'b1, 28},
        '{8'd0,   8'd0,   8'd1,   1'b1, 1'b0, 1'b1, 30},
        '{8'd59,  8'd34,  8'd63,  1'b0, 1'b0, 1'b1, 25},
        '{8'd59,  8'd34,  8'd4,   1'b0, 1'b0, 1'b0, 30}
    };

    script_text_tokenizer #(
        .LINE_BITS(LINE_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_text_byte    (i_text_byte),
        .i_final_byte   (i_final_byte),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_kind         (o_kind),
        .o_char_value   (o_char_value),
        .o_is_quoted    (o_is_quoted),
        .o_token_length (o_token_length),
        .o_line_number  (o_line_number),
        .o_last_of_run  (o_last_of_run)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("script_text_tokenizer regression: fail");
        $finish;
    end

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    task automatic compare_word(string where, tok_word_t got, tok_word_t want, bit with_last);
        if (got.kind !== want.kind)     report_mismatch({where, " kind"}, got.kind, want.kind);
        if (got.ch !== want.ch)         report_mismatch({where, " char"}, got.ch, want.ch);
        if (got.quoted !== want.quoted) report_mismatch({where, " quoted"}, got.quoted, want.quoted);
        if (got.len !== want.len)       report_mismatch({where, " length"}, got.len, want.len);
        if (got.line !== want.line)     report_mismatch({where, " line"}, got.line, want.line);
        if (with_last && got.last !== want.last)
            report_mismatch({where, " last"}, got.last, want.last);
    endtask

    // ---------------- predictor ----------------
    task automatic queue_word(t_kind k, logic [7:0] c, logic q, logic [7:0] l);
        tok_word_t w;
        w.kind   = k;
        w.ch     = c;
        w.quoted = q;
        w.len    = l;
        w.line   = line_m;
        w.last   = 1'b0;
        expected_words.push_back(w);
    endtask

    task automatic advance_line();
        if (line_m != '1)
            line_m = line_m + 1'b1;
    endtask

    task automatic keep_char(logic [7:0] c, logic q);
        logic [7:0] limit;
        limit   = (max_m == 8'd0) ? 8'd1 : max_m;
        chars_m = chars_m + 8'd1;
        queue_word(KIND_CHAR, c, q, chars_m);
        if (chars_m >= limit) begin
            queue_word(KIND_TOKEN_END, 8'd0, q, chars_m);
            scan_mode_m = q ? MODE_DROP : MODE_SKIP;
        end
    endtask

    // byte seen between tokens; whitespace beats comment beats quote
    task automatic open_or_skip(logic [7:0] c);
        if (c <= WS_MAX) begin
            scan_mode_m = MODE_SKIP;
            if (c == NEWLINE)
                advance_line();
        end else if (c == comment_m) begin
            scan_mode_m = MODE_COMMENT;
        end else if (c == quote_m) begin
            scan_mode_m = MODE_QUOTED;
            chars_m     = 8'd0;
        end else begin
            scan_mode_m = MODE_PLAIN;
            chars_m     = 8'd0;
            keep_char(c, 1'b0);
        end
    endtask

    task automatic scan_byte(logic [7:0] c, logic fin, output int first_idx);
        tok_word_t w;
        first_idx = expected_words.size();
        case (scan_mode_m)
            MODE_COMMENT: begin
                if (c == NEWLINE) begin
                    advance_line();
                    scan_mode_m = MODE_SKIP;
                end
            end
            MODE_PLAIN: begin
                if (c > WS_MAX && c != comment_m) begin
                    keep_char(c, 1'b0);
                end else begin
                    queue_word(KIND_TOKEN_END, 8'd0, 1'b0, chars_m);
                    open_or_skip(c);
                end
            end
            MODE_QUOTED: begin
                if (c == quote_m) begin
                    queue_word(KIND_TOKEN_END, 8'd0, 1'b1, chars_m);
                    scan_mode_m = MODE_SKIP;
                end else begin
                    keep_char(c, 1'b1);
                end
            end
            MODE_DROP: scan_mode_m = MODE_SKIP;
            default:   open_or_skip(c);
        endcase
        if (fin) begin
            if (scan_mode_m == MODE_PLAIN)
                queue_word(KIND_TOKEN_END, 8'd0, 1'b0, chars_m);
            else if (scan_mode_m == MODE_QUOTED)
                queue_word(KIND_TOKEN_END, 8'd0, 1'b1, chars_m);
            queue_word(KIND_SCRIPT_END, 8'd0, 1'b0, 8'd0);
            scan_mode_m = MODE_SKIP;
            chars_m     = 8'd0;
            line_m      = 1;
        end
        if (expected_words.size() > first_idx) begin
            w      = expected_words.pop_back();
            w.last = 1'b1;
            expected_words.push_back(w);
        end
    endtask

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin : word_monitor
        tok_word_t got;
        tok_word_t pin_w;
        int        first_idx;
        if (!i_rst_n) begin
            scan_mode_m = MODE_SKIP;
            chars_m     = 8'd0;
            line_m      = 1;
            comment_m   = RST_COMMENT;
            quote_m     = RST_QUOTE;
            max_m       = RST_MAX;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_COMMENT_CHAR: comment_m = i_cfg_data;
                    REG_QUOTE_CHAR:   quote_m   = i_cfg_data;
                    REG_MAX_CHARS:    max_m     = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_push && !o_full) begin
                scan_byte(i_text_byte, i_final_byte, first_idx);
                if (cur_row.pinned) begin
                    if (expected_words.size() == first_idx) begin
                        report_mismatch("directed row word count", 0, 1);
                    end else begin
                        pin_w.kind   = cur_row.kind;
                        pin_w.ch     = cur_row.ch;
                        pin_w.quoted = cur_row.quoted;
                        pin_w.len    = cur_row.len;
                        pin_w.line   = cur_row.line;
                        pin_w.last   = 1'b0;
                        compare_word("directed row", expected_words[first_idx], pin_w, 1'b0);
                    end
                end
            end
            if (i_pop && !o_empty) begin
                got.kind   = t_kind'(o_kind);
                got.ch     = o_char_value;
                got.quoted = o_is_quoted;
                got.len    = o_token_length;
                got.line   = o_line_number;
                got.last   = o_last_of_run;
                if (expected_words.size() == 0)
                    report_mismatch("unexpected word, kind", o_kind, 0);
                else
                    compare_word("result word", got, expected_words.pop_front(), 1'b1);
            end
        end
    end

    // ---------------- receiver ----------------
    initial begin : pop_driver
        int stall;
        i_pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_pop <= 1'b0;
                stall = $urandom_range(1, 17);
                repeat (stall - 1) @(negedge i_clk);
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    // ---------------- sender ----------------
    function automatic stim_row_t text_row(logic [7:0] c, logic fin);
        stim_row_t r;
        r.b      = c;
        r.fin    = fin;
        r.pinned = 1'b0;
        r.kind   = KIND_CHAR;
        r.ch     = 8'd0;
        r.quoted = 1'b0;
        r.len    = 8'd0;
        r.line   = '0;
        return r;
    endfunction

    task automatic send_byte(stim_row_t r);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_push <= 1'b0;
            gap = $urandom_range(1, 17);
            repeat (gap) @(negedge i_clk);
        end
        cur_row = r;
        i_text_byte  <= r.b;
        i_final_byte <= r.fin;
        i_push       <= 1'b1;
        do @(posedge i_clk); while (o_full);
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // one script: words, whitespace, comments, quoted strings and noise, ending on the final byte
    task automatic build_script(logic [7:0] cc, logic [7:0] qc, logic [7:0] cap);
        int         pieces;
        int         len;
        int         limit;
        int         sel;
        int         n;
        logic [7:0] c;
        stim_row_t  r;
        script_bytes.delete();
        limit  = (cap == 8'd0) ? 1 : int'(cap);
        pieces = $urandom_range(1, 6);
        for (int p = 0; p < pieces; p++) begin
            if (limit <= 16 && $urandom_range(0, 2) == 0)
                len = limit - 1 + $urandom_range(0, 2);
            else
                len = $urandom_range(1, 6);
            sel = $urandom_range(0, 9);
            case (sel)
                0, 1, 2, 3: begin
                    for (int i = 0; i < len; i++) begin
                        do c = 8'($urandom_range(33, 255));
                        while (c == cc || (i == 0 && c == qc));
                        script_bytes.push_back(text_row(c, 1'b0));
                    end
                    if ($urandom_range(0, 1) == 0)
                        script_bytes.push_back(text_row($urandom_range(0, 1) ? 8'h20 : NEWLINE,
                                                        1'b0));
                end
                4, 5: begin
                    repeat ($urandom_range(1, 3)) begin
                        case ($urandom_range(0, 2))
                            0:       c = 8'h20;
                            1:       c = NEWLINE;
                            default: c = 8'($urandom_range(0, 32));
                        endcase
                        script_bytes.push_back(text_row(c, 1'b0));
                    end
                end
                6: begin
                    script_bytes.push_back(text_row(cc, 1'b0));
                    repeat ($urandom_range(0, 4)) begin
                        do c = 8'($urandom_range(0, 255)); while (c == NEWLINE);
                        script_bytes.push_back(text_row(c, 1'b0));
                    end
                    script_bytes.push_back(text_row(NEWLINE, 1'b0));
                end
                7, 8: begin
                    script_bytes.push_back(text_row(qc, 1'b0));
                    n = len - 1 + $urandom_range(0, 1);
                    for (int i = 0; i < n; i++) begin
                        if ($urandom_range(0, 3) == 0)
                            c = NEWLINE;
                        else
                            do c = 8'($urandom_range(0, 255)); while (c == qc);
                        script_bytes.push_back(text_row(c, 1'b0));
                    end
                    script_bytes.push_back(text_row(qc, 1'b0));
                end
                default: begin
                    repeat ($urandom_range(1, 4))
                        script_bytes.push_back(text_row(8'($urandom_range(0, 255)), 1'b0));
                end
            endcase
        end
        if (script_bytes.size() == 0)
            script_bytes.push_back(text_row(8'h20, 1'b0));
        // broken script: cut off inside whatever was open
        if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, script_bytes.size());
            while (script_bytes.size() > n) void'(script_bytes.pop_back());
        end
        r     = script_bytes.pop_back();
        r.fin = 1'b1;
        script_bytes.push_back(r);
    endtask

    initial begin : stimulus
        phase_t     ph;
        logic [7:0] cc;
        logic [7:0] qc;
        logic [7:0] cap;
        int         sent;
        i_rst_n        = 1'b0;
        i_push         = 1'b0;
        i_text_byte    = 8'd0;
        i_final_byte   = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = REG_COMMENT_CHAR;
        i_cfg_data     = 8'd0;
        cur_row.pinned = 1'b0;
        idle_on        = 1'b1;
        hold_req       = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_byte(directed_rows[k]);
        wait_drain();

        foreach (phases[p]) begin
            ph  = phases[p];
            cc  = ph.cmt;
            qc  = ph.quo;
            cap = ph.cap;
            if (ph.rand_cfg) begin
                cc  = 8'($urandom_range(0, 255));
                qc  = 8'($urandom_range(0, 255));
                cap = 8'($urandom_range(1, 8));
            end
            write_reg(REG_COMMENT_CHAR, cc);
            write_reg(REG_QUOTE_CHAR, qc);
            write_reg(REG_MAX_CHARS, cap);
            idle_on  = ph.idle;
            hold_req = ph.hold;
            sent = 0;
            while (sent < ph.items) begin
                build_script(cc, qc, cap);
                foreach (script_bytes[k])
                    send_byte(script_bytes[k]);
                sent += script_bytes.size();
            end
            wait_drain();
        end

        repeat (20) @(posedge i_clk);
        if (err_count == 0)
            $display("script_text_tokenizer regression: pass");
        else
            $display("script_text_tokenizer regression: fail");
        $finish;
    end

endmodule

// ----- script_text_tokenizer.f -----
rtl/stt_pkg.sv
rtl/stt_front.sv
rtl/stt_queue.sv
rtl/stt_back.sv
rtl/script_text_tokenizer.sv
tb/tb_top.sv
